// ===== rtl/b2da_pkg.sv =====
// Shared constants and controller/datapath interface types for the decimal text converter.
package b2da_pkg;

  localparam int IN_W        = 32;
  localparam int DIGIT_COUNT = 10;
  localparam int BCD_W       = 4 * DIGIT_COUNT;
  localparam int CHAR_W      = 6;
  localparam int CNT_W       = $clog2(IN_W);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [CNT_W-1:0]  BIT_LAST   = CNT_W'(IN_W - 1);
  localparam logic [CNT_W-1:0]  DIGIT_LAST = CNT_W'(DIGIT_COUNT - 1);

  typedef struct packed {
    logic load;
    logic dabble;
    logic digit_shift;
  } b2da_cmd_t;

  typedef struct packed {
    logic top_zero;
  } b2da_status_t;

endpackage

// ===== rtl/b2da_dp.sv =====
// Datapath: binary shift register, BCD shift-and-add-3 register and digit output.
module b2da_dp (
  input  logic                         clk,
  input  b2da_pkg::b2da_cmd_t          cmd,
  input  logic [b2da_pkg::IN_W-1:0]    number,
  output b2da_pkg::b2da_status_t       status,
  output logic [b2da_pkg::CHAR_W-1:0]  digit_char
);
  import b2da_pkg::*;

  logic [IN_W-1:0]  bin_r;
  logic [IN_W-1:0]  bin_nxt;
  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] bcd_nxt;
  logic [BCD_W-1:0] bcd_adj;

  always_comb begin
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (cmd.load) begin
      bin_nxt = number;
      bcd_nxt = '0;
    end else if (cmd.dabble) begin
      bin_nxt = {bin_r[IN_W-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[IN_W-1]};
    end else if (cmd.digit_shift) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign status.top_zero = (bcd_r[BCD_W-1 -: 4] == 4'd0);
  assign digit_char      = ASCII_ZERO + {2'b00, bcd_r[BCD_W-1 -: 4]};

endmodule

// ===== rtl/b2da_ctrl.sv =====
// Controller: sequences load, 32 conversion steps, leading-zero skip and digit output.
module b2da_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_last_digit,
  input  b2da_pkg::b2da_status_t  status,
  output b2da_pkg::b2da_cmd_t     cmd
);
  import b2da_pkg::*;

  typedef enum logic [1:0] {IDLE, CONV, SKIP, EMIT} state_t;

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_last_r;
  logic             out_last_nxt;

  assign in_ready       = (state_r == IDLE);
  assign out_valid      = out_valid_r;
  assign out_last_digit = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    cmd           = '0;
    case (state_r)
      IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = BIT_LAST;
          state_nxt = CONV;
        end
      end
      CONV: begin
        cmd.dabble = 1'b1;
        if (cnt_r == '0) begin
          cnt_nxt   = DIGIT_LAST;
          state_nxt = SKIP;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      SKIP: begin
        if (status.top_zero && (cnt_r != '0)) begin
          cmd.digit_shift = 1'b1;
          cnt_nxt         = cnt_r - 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (cnt_r == '0);
          state_nxt     = EMIT;
        end
      end
      EMIT: begin
        if (out_ready) begin
          if (cnt_r == '0) begin
            out_valid_nxt = 1'b0;
            out_last_nxt  = 1'b0;
            state_nxt     = IDLE;
          end else begin
            cmd.digit_shift = 1'b1;
            cnt_nxt         = cnt_r - 1'b1;
            out_last_nxt    = (cnt_r == CNT_W'(1));
          end
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

endmodule

// ===== rtl/binary_to_decimal_ascii_top.sv =====
// Top level of the binary to decimal ASCII converter.
//
//   Channel   Ports                                   Direction  Word
//   in        in_valid, in_ready, in_number           input      one 32-bit unsigned value
//   out       out_valid, out_ready, out_digit_char,   output     one ASCII digit, MSD first
//             out_last_digit
//
// Each value passes through an accept step, 32 shift-and-add-3 steps, leading-zero skip
// and digit output; a stalled output holds the current digit until it is taken.
// Reset is synchronous and active low; it returns the
// controller to idle and drops out_valid. A new word is accepted only after the last digit
// of the previous one has been taken.
module binary_to_decimal_ascii_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [b2da_pkg::IN_W-1:0]    in_number,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                         out_last_digit
);
  import b2da_pkg::*;

  b2da_cmd_t    cmd;
  b2da_status_t status;

  b2da_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_last_digit (out_last_digit),
    .status         (status),
    .cmd            (cmd)
  );

  b2da_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .number     (in_number),
    .status     (status),
    .digit_char (out_digit_char)
  );

endmodule
